// File: hdl/segment_tree_range_max_assert.svh
// assertion macros shared by the segment tree range max modules
// no dependencies; included by the files that hold assertions
`ifndef SEGMENT_TREE_RANGE_MAX_ASSERT_SVH
`define SEGMENT_TREE_RANGE_MAX_ASSERT_SVH

`ifndef SYNTHESIS

// overlapping implication, checked at every rising edge out of reset
`define SRMX_ASSERT_OVL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment tree assertion failed");

// non-overlapping implication, consequent checked at the next rising edge
`define SRMX_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment tree assertion failed");

`else

`define SRMX_ASSERT_OVL(name, clk, rst_n, ante, cons)
`define SRMX_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/srmx_pkg.sv
// shared constants, codes and control structs of the segment tree range max block
// no dependencies
`default_nettype none

package srmx_pkg;

    // default sizing
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // input item fields
    localparam int LEFT_W   = 10;
    localparam int RIGHT_W  = 11;
    localparam int NEWVAL_W = 32;
    localparam int LEFT_LSB   = 0;
    localparam int RIGHT_LSB  = LEFT_LSB + LEFT_W;
    localparam int NEWVAL_LSB = RIGHT_LSB + RIGHT_W;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;

    // result item fields
    localparam int RANGE_MAX_W = 32;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 1;

    // operation codes carried on s_tuser
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic load;
        logic start;
        logic leaf_wr;
        logic climb;
        logic q_lo;
        logic q_hi;
        logic res_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic upd_skip;
        logic lo_lt_hi;
        logic at_top;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/srmx_ram.sv
// generic simple dual port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module srmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/srmx_datapath.sv
// datapath: tree store, node index and range registers, accumulator, result register
// depends on srmx_pkg, srmx_ram and segment_tree_range_max_assert.svh
`default_nettype none

`include "segment_tree_range_max_assert.svh"

module srmx_datapath #(
    parameter int LEAVES     = srmx_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = srmx_pkg::VALUE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [srmx_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [srmx_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [srmx_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [srmx_pkg::M_TUSER_W-1:0]   m_tuser,
    input  wire srmx_pkg::ctrl_cmd_t              cmd,
    output srmx_pkg::dp_status_t                  sts
);

    localparam int LEAF_BITS = $clog2(LEAVES);
    localparam int NODE_BITS = LEAF_BITS + 1;
    localparam int IDX_BITS  = NODE_BITS + 1;
    localparam int DEPTH     = 2 * LEAVES;

    // input decode
    logic [srmx_pkg::LEFT_W-1:0]   in_left;
    logic [srmx_pkg::RIGHT_W-1:0]  in_right;
    logic [srmx_pkg::NEWVAL_W-1:0] in_value;
    logic [31:0]                   left32;
    logic [31:0]                   right32;
    logic [31:0]                   hi_sat32;
    logic [IDX_BITS-1:0]           hi_node;
    logic [IDX_BITS-1:0]           lo_node;
    logic [NODE_BITS-1:0]          leaf_node;

    // registers
    logic                  op_reg,        op_next;
    logic                  skip_reg,      skip_next;
    logic [NODE_BITS-1:0]  k_reg,         k_next;
    logic [VALUE_BITS-1:0] val_reg,       val_next;
    logic [VALUE_BITS-1:0] cur_reg,       cur_next;
    logic [VALUE_BITS-1:0] acc_reg,       acc_next;
    logic [IDX_BITS-1:0]   lo_reg,        lo_next;
    logic [IDX_BITS-1:0]   hi_reg,        hi_next;
    logic                  pend_reg,      pend_next;
    logic [NODE_BITS-1:0]  clr_cnt_reg,   clr_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_query_reg, out_query_next;
    logic [31:0]           out_max_reg,   out_max_next;

    // memory port
    logic                  wr_en;
    logic [NODE_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [NODE_BITS-1:0]  rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    logic [NODE_BITS-1:0]  parent;
    logic [VALUE_BITS-1:0] leaf_val;
    logic [VALUE_BITS-1:0] par_val;

    assign in_left  = s_tdata[srmx_pkg::LEFT_LSB +: srmx_pkg::LEFT_W];
    assign in_right = s_tdata[srmx_pkg::RIGHT_LSB +: srmx_pkg::RIGHT_W];
    assign in_value = s_tdata[srmx_pkg::NEWVAL_LSB +: srmx_pkg::NEWVAL_W];

    assign left32   = 32'(in_left);
    assign right32  = 32'(in_right);
    assign hi_sat32 = (right32 > 32'(LEAVES)) ? 32'(LEAVES) : right32;
    assign hi_node  = IDX_BITS'(32'(LEAVES) + hi_sat32);
    // an empty or reversed range collapses to lo equal to hi
    assign lo_node  = (left32 >= hi_sat32) ? hi_node : IDX_BITS'(32'(LEAVES) + left32);
    assign leaf_node = {1'b1, LEAF_BITS'(in_left)};

    assign parent   = k_reg >> 1;
    assign leaf_val = (rd_data > val_reg) ? rd_data : val_reg;
    assign par_val  = (rd_data > cur_reg) ? rd_data : cur_reg;

    srmx_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rd_addr = k_reg;
        if (cmd.leaf_wr)
        begin
            rd_addr = k_reg ^ NODE_BITS'(1);
        end
        else if (cmd.climb)
        begin
            rd_addr = parent ^ NODE_BITS'(1);
        end
        else if (cmd.q_lo)
        begin
            rd_addr = NODE_BITS'(lo_reg);
        end
        else if (cmd.q_hi)
        begin
            rd_addr = NODE_BITS'(hi_reg - IDX_BITS'(1));
        end

        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        if (cmd.clr_en)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.leaf_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = k_reg;
            wr_data = leaf_val;
        end
        else if (cmd.climb)
        begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = par_val;
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        skip_next      = skip_reg;
        k_next         = k_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_query_next = out_query_reg;
        out_max_next   = out_max_reg;

        // fold the node read in the previous cycle
        if (pend_reg)
        begin
            acc_next = (rd_data > acc_reg) ? rd_data : acc_reg;
        end
        pend_next = (cmd.q_lo && lo_reg[0]) || (cmd.q_hi && hi_reg[0]);

        if (cmd.clr_en)
        begin
            clr_cnt_next = clr_cnt_reg + NODE_BITS'(1);
        end

        if (cmd.load)
        begin
            op_next   = s_tuser[0];
            skip_next = left32 >= 32'(LEAVES);
            k_next    = leaf_node;
            val_next  = VALUE_BITS'(in_value);
            acc_next  = '0;
            lo_next   = lo_node;
            hi_next   = hi_node;
        end

        if (cmd.leaf_wr)
        begin
            cur_next = leaf_val;
        end
        if (cmd.climb)
        begin
            cur_next = par_val;
            k_next   = parent;
        end

        if (cmd.q_lo)
        begin
            lo_next = lo_reg + IDX_BITS'(lo_reg[0]);
        end
        // an odd hi steps down before the shift, which the shift absorbs
        if (cmd.q_hi)
        begin
            lo_next = lo_reg >> 1;
            hi_next = hi_reg >> 1;
        end

        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
            out_query_next = op_reg;
            out_max_next   = (op_reg == srmx_pkg::CMD_QUERY) ? 32'(acc_reg) : 32'd0;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
        end
        else
        begin
            pend_reg      <= pend_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        skip_reg      <= skip_next;
        k_reg         <= k_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        acc_reg       <= acc_next;
        out_query_reg <= out_query_next;
        out_max_reg   <= out_max_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_max_reg;
    assign m_tuser  = out_query_reg;

    assign sts.clr_last = &clr_cnt_reg;
    assign sts.is_query = (op_reg == srmx_pkg::CMD_QUERY);
    assign sts.upd_skip = skip_reg;
    assign sts.lo_lt_hi = lo_reg < hi_reg;
    assign sts.at_top   = (parent == NODE_BITS'(1));
    assign sts.out_free = !out_valid_reg || m_tready;

    `SRMX_ASSERT_OVL(a_lo_not_past_hi, clk, rst_n, 1'b1, lo_reg <= hi_reg)
    `SRMX_ASSERT_OVL(a_climb_below_root, clk, rst_n, cmd.climb, parent != '0)
    `SRMX_ASSERT_OVL(a_result_slot_free, clk, rst_n, cmd.res_load, !out_valid_reg || m_tready)

endmodule

`default_nettype wire

// File: hdl/srmx_ctrl.sv
// controller: sequences the clearing pass, leaf update climb and range query walk
// depends on srmx_pkg and segment_tree_range_max_assert.svh
`default_nettype none

`include "segment_tree_range_max_assert.svh"

module srmx_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire srmx_pkg::dp_status_t sts,
    output srmx_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_LEAF_WR,
        ST_CLIMB,
        ST_Q_LO,
        ST_Q_HI,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.is_query)
                begin
                    state_next = ST_Q_LO;
                end
                else if (sts.upd_skip)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_LEAF_WR;
                end
            end
            ST_LEAF_WR:
            begin
                cmd.leaf_wr = 1'b1;
                state_next  = ST_CLIMB;
            end
            ST_CLIMB:
            begin
                cmd.climb = 1'b1;
                if (sts.at_top)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_Q_LO:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.q_lo   = 1'b1;
                    state_next = ST_Q_HI;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_Q_HI:
            begin
                cmd.q_hi   = 1'b1;
                state_next = ST_Q_LO;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    `SRMX_ASSERT_NXT(a_one_item_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SRMX_ASSERT_NXT(a_clear_runs_to_end, clk, rst_n, cmd.clr_en && !sts.clr_last, cmd.clr_en)
    `SRMX_ASSERT_NXT(a_leaf_write_after_read, clk, rst_n, cmd.start, cmd.leaf_wr)

endmodule

`default_nettype wire

// File: hdl/segment_tree_range_max.sv
// top level of the segment tree range max block: controller plus datapath
// depends on srmx_pkg, srmx_ctrl and srmx_datapath
`default_nettype none

// Range maximum segment tree over LEAVES leaves (a power of two), one item at a time.
// An update (tuser 0) max-merges new_value into leaf left_index and rewrites all its
// ancestors up to the root; a query (tuser 1) returns the maximum over the leaves
// [left_index, right_end), zero when that range is empty. Every item gives one result
// transfer. The tree lives in a single 2*LEAVES-entry ram with one read and one write
// port, so the walk over the tree levels sets the rate; a query makes two ram reads per
// level. A new item is taken only after the last one has reached the output register.
// After reset the block zeroes every ram entry and holds s_tready low until that is
// done. A finished result sits in an output register, so the next item is taken while
// it waits.

module segment_tree_range_max #(
    parameter int LEAVES     = srmx_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = srmx_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // left_index [9:0], right_end [20:10], new_value [52:21], zero [55:53]
    input  wire logic [srmx_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [0]
    input  wire logic [srmx_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // range_max [31:0]
    output logic      [srmx_pkg::M_TDATA_W-1:0] m_tdata,
    // was_query [0]
    output logic      [srmx_pkg::M_TUSER_W-1:0] m_tuser
);

    srmx_pkg::ctrl_cmd_t  cmd;
    srmx_pkg::dp_status_t sts;

    srmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srmx_datapath #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

// File: dv/segment_tree_range_max_test.sv
// self-checking testbench for segment_tree_range_max: directed corner items, then random
// update/query traffic under three sender and receiver stall patterns
// depends on srmx_pkg and segment_tree_range_max
`default_nettype none

module segment_tree_range_max_test;

    localparam int NUM_LEAVES  = srmx_pkg::LEAVES_DEF;
    localparam int LEFT_W      = srmx_pkg::LEFT_W;
    localparam int RIGHT_W     = srmx_pkg::RIGHT_W;
    localparam int NEWVAL_W    = srmx_pkg::NEWVAL_W;
    localparam int S_TDATA_W   = srmx_pkg::S_TDATA_W;
    localparam int S_TUSER_W   = srmx_pkg::S_TUSER_W;
    localparam int M_TDATA_W   = srmx_pkg::M_TDATA_W;
    localparam int M_TUSER_W   = srmx_pkg::M_TUSER_W;
    localparam int RANGE_MAX_W = srmx_pkg::RANGE_MAX_W;
    localparam int PAD_W       = S_TDATA_W - srmx_pkg::NEWVAL_LSB - NEWVAL_W;

    typedef struct {
        logic                   was_query;
        logic [RANGE_MAX_W-1:0] range_max;
    } answer_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // shadow copy of the leaf values; internal nodes are not needed for prediction
    logic [NEWVAL_W-1:0] leaf_values [NUM_LEAVES];
    answer_t             pending_answers [$];
    answer_t             oldest_answer;
    int                  mismatch_count  = 0;
    int                  send_idle_pct   = 36;
    int                  ready_idle_pct  = 57;

    segment_tree_range_max dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= ready_idle_pct);
    end

    function automatic answer_t merge_or_query(
        input logic                op,
        input logic [LEFT_W-1:0]   lft,
        input logic [RIGHT_W-1:0]  rgt,
        input logic [NEWVAL_W-1:0] val
    );
        answer_t ans;
        int      hi;
        ans.was_query = (op == srmx_pkg::CMD_QUERY);
        ans.range_max = '0;
        if (op == srmx_pkg::CMD_UPDATE)
        begin
            if (val > leaf_values[lft])
                leaf_values[lft] = val;
        end
        else
        begin
            // range end saturates at the leaf count; reversed ranges fall through as empty
            hi = (rgt > NUM_LEAVES) ? NUM_LEAVES : int'(rgt);
            for (int i = int'(lft); i < hi; i++)
                if (leaf_values[i] > ans.range_max)
                    ans.range_max = leaf_values[i];
        end
        return ans;
    endfunction

    task automatic send_item(
        input logic                op,
        input logic [LEFT_W-1:0]   lft,
        input logic [RIGHT_W-1:0]  rgt,
        input logic [NEWVAL_W-1:0] val
    );
        answer_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, val, rgt, lft};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected        = merge_or_query(op, lft, rgt, val);
        pending_answers = {pending_answers, expected};
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result transfer: range_max %0h was_query %0b",
                       m_tdata, m_tuser[0]);
                mismatch_count++;
            end
            else
            begin
                oldest_answer = pending_answers.pop_front();
                if (m_tuser[0] !== oldest_answer.was_query)
                begin
                    $error("was_query: expected %0b, actual %0b",
                           oldest_answer.was_query, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tdata !== oldest_answer.range_max)
                begin
                    $error("range_max: expected %0h, actual %0h",
                           oldest_answer.range_max, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_item(srmx_pkg::CMD_QUERY,  10'd0,    11'd1024, 32'h0);
        send_item(srmx_pkg::CMD_UPDATE, 10'd0,    11'd2047, 32'd5);
        send_item(srmx_pkg::CMD_UPDATE, 10'd1023, 11'd0,    32'hFFFF_FFFF);
        send_item(srmx_pkg::CMD_QUERY,  10'd0,    11'd1024, 32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd0,    11'd1023, 32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd1023, 11'd1024, 32'h0);
        // end past the leaves
        send_item(srmx_pkg::CMD_QUERY,  10'd1023, 11'd2047, 32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd2,    11'd1025, 32'h0);
        // reversed and empty ranges
        send_item(srmx_pkg::CMD_QUERY,  10'd10,   11'd3,    32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd7,    11'd7,    32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd0,    11'd0,    32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd1023, 11'd0,    32'h0);
        // smaller value must not lower the leaf
        send_item(srmx_pkg::CMD_UPDATE, 10'd0,    11'd1,    32'd3);
        send_item(srmx_pkg::CMD_QUERY,  10'd0,    11'd1,    32'h0);
        send_item(srmx_pkg::CMD_UPDATE, 10'd0,    11'd0,    32'h0);
        send_item(srmx_pkg::CMD_UPDATE, 10'd512,  11'd0,    32'h8000_0000);
        send_item(srmx_pkg::CMD_QUERY,  10'd511,  11'd513,  32'h0);
        send_item(srmx_pkg::CMD_UPDATE, 10'd511,  11'd1024, 32'h7FFF_FFFF);
        // value field is ignored on a query
        send_item(srmx_pkg::CMD_QUERY,  10'd0,    11'd512,  32'hFFFF_FFFF);
        send_item(srmx_pkg::CMD_QUERY,  10'd1,    11'd1023, 32'h0);
        send_item(srmx_pkg::CMD_UPDATE, 10'd300,  11'd5,    32'd1);
        send_item(srmx_pkg::CMD_QUERY,  10'd300,  11'd301,  32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd299,  11'd300,  32'h0);
        send_item(srmx_pkg::CMD_QUERY,  10'd1,    11'd1024, 32'h0);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int ready_pct);
        logic                op;
        logic [LEFT_W-1:0]   lft;
        logic [RIGHT_W-1:0]  rgt;
        logic [NEWVAL_W-1:0] val;
        send_idle_pct  = send_pct;
        ready_idle_pct = ready_pct;
        for (int n = 0; n < count; n++)
        begin
            op  = 1'($urandom_range(1));
            lft = LEFT_W'($urandom_range(NUM_LEAVES - 1));
            case ($urandom_range(9))
                0:       rgt = RIGHT_W'($urandom_range(2047));
                1:       rgt = RIGHT_W'($urandom_range(int'(lft)));
                2:       rgt = RIGHT_W'(NUM_LEAVES + $urandom_range(NUM_LEAVES - 1));
                3, 4, 5: rgt = RIGHT_W'(int'(lft) + 1 + $urandom_range(15));
                default: rgt = RIGHT_W'(int'(lft) + 1
                                        + $urandom_range(NUM_LEAVES - 1 - int'(lft)));
            endcase
            case ($urandom_range(5))
                0:       val = NEWVAL_W'($urandom_range(255));
                1:       val = NEWVAL_W'(32'hFFFF_FFFF - $urandom_range(3));
                default: val = NEWVAL_W'($urandom);
            endcase
            send_item(op, lft, rgt, val);
        end
    endtask

    initial
    begin
        foreach (leaf_values[i])
            leaf_values[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(240, 36, 57);
        test_random_traffic(240, 57, 36);
        test_random_traffic(220, 0, 0);

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        // allow a stray late transfer to show up
        repeat (60) @(posedge clk);

        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
